@@ rtl/vds_pkg.sv @@
// Package with shared types, register indexes and stencil tables of the voxel stencil core.
`timescale 1ns / 1ps

package vds_pkg;

  // Fixed field widths
  localparam int COORD_W    = 5;
  localparam int SAMPLE_W   = 16;
  localparam int OUT_D_W    = 35;
  localparam int INV_W      = 16;
  localparam int COEF_W     = 32;
  localparam int SIZE_W     = 6;
  localparam int DIM_W      = 9;
  localparam int CRD_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_VALUE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DX       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DY       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DZ       = 3'd7;

  // Register reset values
  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;
  localparam logic [INV_W-1:0]  INV_RST  = 16'd256;

  // Item kinds and border modes
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;
  localparam logic BORDER_FIXED = 1'b0;
  localparam logic BORDER_REPL  = 1'b1;

  // Saturation limit of a derivative
  localparam logic [63:0] OUT_D_MAX = 64'h0000_0003_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DRAIN,
    ST_OUT
  } vds_state_t;

  // What a fetched neighbor contributes to
  typedef enum logic [3:0] {
    ROLE_C, ROLE_XM, ROLE_XP, ROLE_YM, ROLE_YP, ROLE_ZM, ROLE_ZP,
    ROLE_SXY, ROLE_SXZ, ROLE_SYZ
  } role_t;

  // Rounding shift of a derivative term
  typedef enum logic [1:0] {
    SH_FIRST,
    SH_SECOND,
    SH_MIXED
  } shift_t;

  // Stencil of a query: the center and its face and edge neighbors
  localparam int NB_NUM = 19;
  localparam int NB_W   = 5;
  localparam logic [NB_W-1:0] NB_LAST = 5'd18;

  localparam logic signed [1:0] NB_DX [0:NB_NUM-1] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
    -2'sd1, 2'sd1, 2'sd1, -2'sd1,
    -2'sd1, 2'sd1, 2'sd1, -2'sd1,
    2'sd0, 2'sd0, 2'sd0, 2'sd0};
  localparam logic signed [1:0] NB_DY [0:NB_NUM-1] = '{
    2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0,
    -2'sd1, -2'sd1, 2'sd1, 2'sd1,
    2'sd0, 2'sd0, 2'sd0, 2'sd0,
    -2'sd1, 2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] NB_DZ [0:NB_NUM-1] = '{
    2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1,
    2'sd0, 2'sd0, 2'sd0, 2'sd0,
    -2'sd1, -2'sd1, 2'sd1, 2'sd1,
    -2'sd1, -2'sd1, 2'sd1, 2'sd1};
  localparam role_t NB_ROLE [0:NB_NUM-1] = '{
    ROLE_C, ROLE_XM, ROLE_XP, ROLE_YM, ROLE_YP, ROLE_ZM, ROLE_ZP,
    ROLE_SXY, ROLE_SXY, ROLE_SXY, ROLE_SXY,
    ROLE_SXZ, ROLE_SXZ, ROLE_SXZ, ROLE_SXZ,
    ROLE_SYZ, ROLE_SYZ, ROLE_SYZ, ROLE_SYZ};
  // Mixed sums subtract every second corner
  localparam logic NB_NEG [0:NB_NUM-1] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b1};

  // Derivative terms in result order
  localparam int TERM_W = 4;
  localparam logic [TERM_W-1:0] T_UX  = 4'd1;
  localparam logic [TERM_W-1:0] T_UY  = 4'd2;
  localparam logic [TERM_W-1:0] T_UZ  = 4'd3;
  localparam logic [TERM_W-1:0] T_UXX = 4'd4;
  localparam logic [TERM_W-1:0] T_UXY = 4'd5;
  localparam logic [TERM_W-1:0] T_UXZ = 4'd6;
  localparam logic [TERM_W-1:0] T_UYY = 4'd7;
  localparam logic [TERM_W-1:0] T_UYZ = 4'd8;
  localparam logic [TERM_W-1:0] T_UZZ = 4'd9;

endpackage

@@ rtl/vds_if.sv @@
// Valid/ready channel interfaces for the query input and the derivative result.
`timescale 1ns / 1ps

interface vds_in_if;
  import vds_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [COORD_W-1:0]         x;
  logic [COORD_W-1:0]         y;
  logic [COORD_W-1:0]         z;
  logic signed [SAMPLE_W-1:0] value;

  modport source (output valid, kind, x, y, z, value, input ready);
  modport sink   (input valid, kind, x, y, z, value, output ready);
endinterface

interface vds_out_if;
  import vds_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] u;
  logic signed [OUT_D_W-1:0]  ux;
  logic signed [OUT_D_W-1:0]  uy;
  logic signed [OUT_D_W-1:0]  uz;
  logic signed [OUT_D_W-1:0]  uxx;
  logic signed [OUT_D_W-1:0]  uxy;
  logic signed [OUT_D_W-1:0]  uxz;
  logic signed [OUT_D_W-1:0]  uyy;
  logic signed [OUT_D_W-1:0]  uyz;
  logic signed [OUT_D_W-1:0]  uzz;

  modport source (output valid, u, ux, uy, uz, uxx, uxy, uxz, uyy, uyz, uzz, input ready);
  modport sink   (input valid, u, ux, uy, uz, uxx, uxy, uxz, uyy, uyz, uzz, output ready);
endinterface

@@ rtl/vds_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module vds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One access per cycle: a read, or a write that also reads out the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/voxel_derivative_stencil_core.sv @@
// Voxel stencil core: stored volume with central-difference derivative queries.
// A write transaction is accepted in the idle state; a query steps through the neighbor read, multiply,
// drain and output states before its result turns valid, and the next transaction is accepted after the
// output state, later while an earlier result still waits in the output register.
// Reset (synchronous, active low) restores the configuration and control registers; the voxel RAM is not cleared.
`timescale 1ns / 1ps

module voxel_derivative_stencil_core #(
  parameter int MAX_DIM     = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  vds_in_if.sink                           in_ch,
  vds_out_if.source                        out_ch
);

  import vds_pkg::*;

  localparam int AW = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
  localparam int SW = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int DW = SW + 4;
  localparam int PW = DW + COEF_W;
  localparam logic [PW:0] LIM_POS = (PW+1)'(OUT_D_MAX);
  localparam logic [PW:0] LIM_NEG = LIM_POS + (PW+1)'(1);
  localparam logic signed [SW-1:0] SMP_HI = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMP_LO = -SMP_HI - SW'(1);
  localparam logic signed [SW-1:0] U_HI = SW'(32767);
  localparam logic signed [SW-1:0] U_LO = SW'(-32768);

  // Size register as used: zero acts as one, above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] size_used(input logic [SIZE_W-1:0] r);
    if (r == '0) begin
      return DIM_W'(1);
    end else if (DIM_W'(r) > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(r);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [DIM_W-1:0] xa,
                                             input logic [DIM_W-1:0] ya,
                                             input logic [DIM_W-1:0] za);
    return AW'((32'(za) * MAX_DIM + 32'(ya)) * MAX_DIM + 32'(xa));
  endfunction

  function automatic logic [DIM_W-1:0] clamp_q(input logic [COORD_W-1:0] v,
                                               input logic [DIM_W-1:0] n);
    return (DIM_W'(v) >= n) ? n - DIM_W'(1) : DIM_W'(v);
  endfunction

  // Neighbor coordinate clamped into the volume
  function automatic logic [DIM_W-1:0] clamp_nb(input logic signed [CRD_W-1:0] c,
                                                input logic [DIM_W-1:0] n);
    if (c < 0) begin
      return '0;
    end else if (c >= $signed({1'b0, n})) begin
      return n - DIM_W'(1);
    end
    return c[DIM_W-1:0];
  endfunction

  // Configuration registers
  logic [SIZE_W-1:0]          x_size_r, y_size_r, z_size_r;
  logic                       border_mode_r;
  logic signed [SAMPLE_W-1:0] border_value_r;
  logic [INV_W-1:0]           inv_dx_r, inv_dy_r, inv_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_size_r       <= SIZE_RST;
      y_size_r       <= SIZE_RST;
      z_size_r       <= SIZE_RST;
      border_mode_r  <= BORDER_REPL;
      border_value_r <= '0;
      inv_dx_r       <= INV_RST;
      inv_dy_r       <= INV_RST;
      inv_dz_r       <= INV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_SIZE:       x_size_r       <= cfg_wdata[SIZE_W-1:0];
        CFG_Y_SIZE:       y_size_r       <= cfg_wdata[SIZE_W-1:0];
        CFG_Z_SIZE:       z_size_r       <= cfg_wdata[SIZE_W-1:0];
        CFG_BORDER_MODE:  border_mode_r  <= cfg_wdata[0];
        CFG_BORDER_VALUE: border_value_r <= $signed(cfg_wdata[SAMPLE_W-1:0]);
        CFG_INV_DX:       inv_dx_r       <= cfg_wdata[INV_W-1:0];
        CFG_INV_DY:       inv_dy_r       <= cfg_wdata[INV_W-1:0];
        CFG_INV_DZ:       inv_dz_r       <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] nx, ny, nz;
  assign nx = size_used(x_size_r);
  assign ny = size_used(y_size_r);
  assign nz = size_used(z_size_r);

  // Control state
  vds_state_t state_r, state_nxt;
  logic [NB_W-1:0]   nb_idx_r;
  logic [TERM_W-1:0] tk_r;
  logic              in_accept;
  logic              wr_inside;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
  logic              out_load;
  logic              out_valid_r;
  logic              v1_r, v2_r;

  // Query coordinates, clamped at acceptance
  logic [DIM_W-1:0] qx_r, qy_r, qz_r;

  // Write path: saturate to the stored sample width
  logic signed [SW-1:0] wr_ext, wr_sat;
  assign wr_ext = SW'(in_ch.value);
  assign wr_sat = (wr_ext > SMP_HI) ? SMP_HI : ((wr_ext < SMP_LO) ? SMP_LO : wr_ext);
  assign ram_wdata = wr_sat[SAMPLE_BITS-1:0];
  assign wr_inside = (DIM_W'(in_ch.x) < nx) && (DIM_W'(in_ch.y) < ny) &&
                     (DIM_W'(in_ch.z) < nz);

  // Neighbor address generation
  logic signed [CRD_W-1:0] xi, yi, zi;
  logic nb_inside, nb_border;
  assign xi = $signed({1'b0, qx_r}) + CRD_W'(NB_DX[nb_idx_r]);
  assign yi = $signed({1'b0, qy_r}) + CRD_W'(NB_DY[nb_idx_r]);
  assign zi = $signed({1'b0, qz_r}) + CRD_W'(NB_DZ[nb_idx_r]);
  assign nb_inside = (xi >= 0) && (xi < $signed({1'b0, nx})) &&
                     (yi >= 0) && (yi < $signed({1'b0, ny})) &&
                     (zi >= 0) && (zi < $signed({1'b0, nz}));
  assign nb_border = !nb_inside && (border_mode_r == BORDER_FIXED);

  // Next state and RAM port control
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = addr_of(clamp_nb(xi, nx), clamp_nb(yi, ny), clamp_nb(zi, nz));
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_addr    = addr_of(DIM_W'(in_ch.x), DIM_W'(in_ch.y), DIM_W'(in_ch.z));
        if (in_ch.valid) begin
          if (in_ch.kind == KIND_QUERY) begin
            state_nxt = ST_READ;
          end else begin
            ram_we = wr_inside;
          end
        end
      end
      ST_READ: begin
        if (nb_idx_r == NB_LAST) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (tk_r == T_UZZ) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  vds_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DIM * MAX_DIM * MAX_DIM)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencing counters and the read return tag
  logic              rd_vld_r, rd_border_r;
  logic [NB_W-1:0]   rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_idx_r <= '0;
      tk_r     <= T_UX;
      rd_vld_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_READ);
      v1_r     <= (state_r == ST_MUL);
      v2_r     <= v1_r;
      if (state_r == ST_READ && nb_idx_r != NB_LAST) begin
        nb_idx_r <= nb_idx_r + NB_W'(1);
      end else begin
        nb_idx_r <= '0;
      end
      if (state_r == ST_MUL) begin
        tk_r <= tk_r + TERM_W'(1);
      end else begin
        tk_r <= T_UX;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= nb_idx_r;
    rd_border_r <= nb_border;
    if (in_accept) begin
      qx_r <= clamp_q(in_ch.x, nx);
      qy_r <= clamp_q(in_ch.y, ny);
      qz_r <= clamp_q(in_ch.z, nz);
    end
  end

  // Accumulate returned samples into the stencil sums
  logic signed [SW-1:0] samp;
  logic signed [SW-1:0] c_r, xm_r, xp_r, ym_r, yp_r, zm_r, zp_r;
  logic signed [DW-1:0] sxy_r, sxz_r, syz_r, samp_d;
  assign samp   = rd_border_r ? SW'(border_value_r) : SW'($signed(ram_rdata));
  assign samp_d = NB_NEG[rd_idx_r] ? -DW'(samp) : DW'(samp);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sxy_r <= '0;
      sxz_r <= '0;
      syz_r <= '0;
    end else if (rd_vld_r) begin
      case (NB_ROLE[rd_idx_r])
        ROLE_C:   c_r   <= samp;
        ROLE_XM:  xm_r  <= samp;
        ROLE_XP:  xp_r  <= samp;
        ROLE_YM:  ym_r  <= samp;
        ROLE_YP:  yp_r  <= samp;
        ROLE_ZM:  zm_r  <= samp;
        ROLE_ZP:  zp_r  <= samp;
        ROLE_SXY: sxy_r <= sxy_r + samp_d;
        ROLE_SXZ: sxz_r <= sxz_r + samp_d;
        ROLE_SYZ: syz_r <= syz_r + samp_d;
        default: ;
      endcase
    end
  end

  // Stage 1: select the stencil sum and form the coefficient
  logic signed [DW-1:0] d_sel;
  logic [INV_W-1:0]     fa_sel, fb_sel;
  shift_t               sh_sel;

  always_comb begin
    d_sel  = '0;
    fa_sel = inv_dx_r;
    fb_sel = INV_W'(1);
    sh_sel = SH_FIRST;
    case (tk_r)
      T_UX: d_sel = DW'(xp_r) - DW'(xm_r);
      T_UY: begin
        d_sel  = DW'(yp_r) - DW'(ym_r);
        fa_sel = inv_dy_r;
      end
      T_UZ: begin
        d_sel  = DW'(zp_r) - DW'(zm_r);
        fa_sel = inv_dz_r;
      end
      T_UXX: begin
        d_sel  = DW'(xp_r) - (DW'(c_r) <<< 1) + DW'(xm_r);
        fb_sel = inv_dx_r;
        sh_sel = SH_SECOND;
      end
      T_UXY: begin
        d_sel  = sxy_r;
        fb_sel = inv_dy_r;
        sh_sel = SH_MIXED;
      end
      T_UXZ: begin
        d_sel  = sxz_r;
        fb_sel = inv_dz_r;
        sh_sel = SH_MIXED;
      end
      T_UYY: begin
        d_sel  = DW'(yp_r) - (DW'(c_r) <<< 1) + DW'(ym_r);
        fa_sel = inv_dy_r;
        fb_sel = inv_dy_r;
        sh_sel = SH_SECOND;
      end
      T_UYZ: begin
        d_sel  = syz_r;
        fa_sel = inv_dy_r;
        fb_sel = inv_dz_r;
        sh_sel = SH_MIXED;
      end
      T_UZZ: begin
        d_sel  = DW'(zp_r) - (DW'(c_r) <<< 1) + DW'(zm_r);
        fa_sel = inv_dz_r;
        fb_sel = inv_dz_r;
        sh_sel = SH_SECOND;
      end
      default: ;
    endcase
  end

  logic signed [DW-1:0] d1_r;
  logic [COEF_W-1:0]    coef1_r;
  shift_t               sh1_r, sh2_r;
  logic [TERM_W-1:0]    k1_r, k2_r;
  logic                 neg2_r;
  logic [PW-1:0]        prod2_r;
  logic [DW-1:0]        mag1;

  assign mag1 = d1_r[DW-1] ? DW'(-d1_r) : DW'(d1_r);

  // Stages 1 and 2: coefficient, then magnitude times coefficient
  always_ff @(posedge clk) begin
    d1_r    <= d_sel;
    coef1_r <= {{(COEF_W-INV_W){1'b0}}, fa_sel} * {{(COEF_W-INV_W){1'b0}}, fb_sel};
    sh1_r   <= sh_sel;
    k1_r    <= tk_r;
    prod2_r <= PW'(mag1) * PW'(coef1_r);
    neg2_r  <= d1_r[DW-1];
    sh2_r   <= sh1_r;
    k2_r    <= k1_r;
  end

  // Stage 3: round half away from zero, saturate, restore the sign
  logic [PW:0] p_ext, p_rnd, p_lim, p_sat;
  logic signed [OUT_D_W-1:0] res3;

  always_comb begin
    p_ext = {1'b0, prod2_r};
    case (sh2_r)
      SH_FIRST:  p_rnd = (p_ext + ((PW+1)'(1) << 8)) >> 9;
      SH_SECOND: p_rnd = (p_ext + ((PW+1)'(1) << 15)) >> 16;
      SH_MIXED:  p_rnd = (p_ext + ((PW+1)'(1) << 17)) >> 18;
      default:   p_rnd = '0;
    endcase
    p_lim = neg2_r ? LIM_NEG : LIM_POS;
    p_sat = (p_rnd > p_lim) ? p_lim : p_rnd;
    res3  = neg2_r ? OUT_D_W'(-p_sat) : OUT_D_W'(p_sat);
  end

  logic signed [OUT_D_W-1:0] res_r [T_UX:T_UZZ];

  always_ff @(posedge clk) begin
    if (v2_r) begin
      res_r[k2_r] <= res3;
    end
  end

  // Output register: holds a finished result while the next item is accepted
  logic signed [SAMPLE_W-1:0] out_u_r;
  logic signed [OUT_D_W-1:0]  out_d_r [T_UX:T_UZZ];
  logic signed [SW-1:0]       u_sat;
  assign u_sat = (c_r > U_HI) ? U_HI : ((c_r < U_LO) ? U_LO : c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_u_r <= u_sat[SAMPLE_W-1:0];
      out_d_r <= res_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.u     = out_u_r;
  assign out_ch.ux    = out_d_r[T_UX];
  assign out_ch.uy    = out_d_r[T_UY];
  assign out_ch.uz    = out_d_r[T_UZ];
  assign out_ch.uxx   = out_d_r[T_UXX];
  assign out_ch.uxy   = out_d_r[T_UXY];
  assign out_ch.uxz   = out_d_r[T_UXZ];
  assign out_ch.uyy   = out_d_r[T_UYY];
  assign out_ch.uyz   = out_d_r[T_UYZ];
  assign out_ch.uzz   = out_d_r[T_UZZ];

endmodule

@@ rtl/vds_checker.sv @@
// Port-level checker of the voxel stencil core and its bind statement.
`timescale 1ns / 1ps

module vds_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_kind,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [15:0]   out_u,
  input logic signed [34:0]   out_ux
);

  import vds_pkg::*;

  // A query transaction occupies the core, so input is refused next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == KIND_QUERY) |=> !in_ready)
    else $error("input ready right after a query transaction");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_u) && $stable(out_ux)))
    else $error("stalled result changed");

  // A new result appears only while the core is busy with a query.
  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the core was idle");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind voxel_derivative_stencil_core vds_checker u_vds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_u     (out_ch.u),
  .out_ux    (out_ch.ux)
);

@@ bench/voxel_derivative_stencil_core_tb.sv @@
// Testbench for the voxel derivative stencil core with a self-checking derivative scoreboard.
`timescale 1ns / 1ps

module voxel_derivative_stencil_core_tb;
  import vds_pkg::*;

  localparam int DIM         = 32;
  localparam int VOL         = DIM * DIM * DIM;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;
  localparam int NUM_PHASES  = 9;
  localparam int RAND_ITEMS  = 140;
  localparam int HOLD_CYCLES = 400;

  // One predicted or observed result transaction.
  typedef struct {
    logic signed [SAMPLE_W-1:0] u;
    logic signed [OUT_D_W-1:0]  d [9];
  } deriv_t;

  // Predicts the derivatives of each query and compares them with the block's results.
  class derivative_board;
    int             voxel_mem [VOL];
    logic [5:0]     size_reg [3];
    bit             repl_mode;
    int             border_val;
    longint unsigned inv_reg [3];
    deriv_t         pending_derivs [$];
    int             fail_count;
    string          names [9];

    function new();
      names = '{"ux", "uy", "uz", "uxx", "uxy", "uxz", "uyy", "uyz", "uzz"};
      size_reg = '{6'd32, 6'd32, 6'd32};
      repl_mode = 1'b1;
      border_val = 0;
      inv_reg = '{256, 256, 256};
      fail_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_X_SIZE:       size_reg[0] = data[5:0];
        CFG_Y_SIZE:       size_reg[1] = data[5:0];
        CFG_Z_SIZE:       size_reg[2] = data[5:0];
        CFG_BORDER_MODE:  repl_mode = data[0];
        CFG_BORDER_VALUE: border_val = $signed(data);
        CFG_INV_DX:       inv_reg[0] = data;
        CFG_INV_DY:       inv_reg[1] = data;
        default:          inv_reg[2] = data;
      endcase
    endfunction

    // A size of zero acts as one and anything above the maximum acts as the maximum.
    function int span(int axis);
      if (size_reg[axis] == 0) return 1;
      if (size_reg[axis] > DIM) return DIM;
      return size_reg[axis];
    endfunction

    function int clip(int v, int hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function longint sample_at(int xi, int yi, int zi);
      int nx, ny, nz;
      nx = span(0);
      ny = span(1);
      nz = span(2);
      if (xi < 0 || xi >= nx || yi < 0 || yi >= ny || zi < 0 || zi >= nz) begin
        if (!repl_mode) return border_val;
        xi = clip(xi, nx - 1);
        yi = clip(yi, ny - 1);
        zi = clip(zi, nz - 1);
      end
      return voxel_mem[(zi * DIM + yi) * DIM + xi];
    endfunction

    // Product rounded to nearest with ties away from zero, then saturated to 35 bits.
    function logic signed [OUT_D_W-1:0] round_sat(longint d, longint unsigned c, int s);
      longint unsigned m, p, lim;
      m = d < 0 ? -d : d;
      lim = d < 0 ? 64'h4_0000_0000 : 64'h3_FFFF_FFFF;
      p = (m * c + (64'd1 << (s - 1))) >> s;
      if (p > lim) p = lim;
      return OUT_D_W'(d < 0 ? -$signed(p) : $signed(p));
    endfunction

    function void note_item(logic kind, int x, int y, int z, logic signed [15:0] v);
      deriv_t e;
      longint c, xm, xp, ym, yp, zm, zp, sxy, sxz, syz;
      longint unsigned ax, ay, az;
      if (kind == KIND_WRITE) begin
        if (x < span(0) && y < span(1) && z < span(2)) voxel_mem[(z * DIM + y) * DIM + x] = v;
        return;
      end
      x = clip(x, span(0) - 1);
      y = clip(y, span(1) - 1);
      z = clip(z, span(2) - 1);
      c  = sample_at(x, y, z);
      xm = sample_at(x - 1, y, z);
      xp = sample_at(x + 1, y, z);
      ym = sample_at(x, y - 1, z);
      yp = sample_at(x, y + 1, z);
      zm = sample_at(x, y, z - 1);
      zp = sample_at(x, y, z + 1);
      sxy = sample_at(x - 1, y - 1, z) - sample_at(x + 1, y - 1, z)
          + sample_at(x + 1, y + 1, z) - sample_at(x - 1, y + 1, z);
      sxz = sample_at(x - 1, y, z - 1) - sample_at(x + 1, y, z - 1)
          + sample_at(x + 1, y, z + 1) - sample_at(x - 1, y, z + 1);
      syz = sample_at(x, y - 1, z - 1) - sample_at(x, y + 1, z - 1)
          + sample_at(x, y + 1, z + 1) - sample_at(x, y - 1, z + 1);
      ax = inv_reg[0];
      ay = inv_reg[1];
      az = inv_reg[2];
      e.u    = SAMPLE_W'(c);
      e.d[0] = round_sat(xp - xm, ax, 9);
      e.d[1] = round_sat(yp - ym, ay, 9);
      e.d[2] = round_sat(zp - zm, az, 9);
      e.d[3] = round_sat(xp - 2 * c + xm, ax * ax, 16);
      e.d[4] = round_sat(sxy, ax * ay, 18);
      e.d[5] = round_sat(sxz, ax * az, 18);
      e.d[6] = round_sat(yp - 2 * c + ym, ay * ay, 16);
      e.d[7] = round_sat(syz, ay * az, 18);
      e.d[8] = round_sat(zp - 2 * c + zm, az * az, 16);
      pending_derivs.push_back(e);
    endfunction

    function void check_result(deriv_t act);
      deriv_t e;
      if (pending_derivs.size() == 0) begin
        $error("result transaction with no query waiting");
        fail_count++;
        return;
      end
      e = pending_derivs.pop_front();
      if (act.u !== e.u) begin
        $error("u: expected %0d, got %0d", e.u, act.u);
        fail_count++;
      end
      for (int k = 0; k < 9; k++) begin
        if (act.d[k] !== e.d[k]) begin
          $error("%s: expected %0d, got %0d", names[k], e.d[k], act.d[k]);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vds_in_if  in_ch ();
  vds_out_if out_ch ();

  voxel_derivative_stencil_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  derivative_board board = new();
  int  send_gap_pct;
  int  recv_stall_pct;
  bit  hold_req;
  bit  hold_taken;
  int  hold_left;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off that lets the block back up.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    deriv_t act;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act.u = out_ch.u;
      act.d = '{out_ch.ux, out_ch.uy, out_ch.uz, out_ch.uxx, out_ch.uxy,
                out_ch.uxz, out_ch.uyy, out_ch.uyz, out_ch.uzz};
      board.check_result(act);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[voxel_derivative_stencil_core] ERROR");
      $finish;
    end
  end

  // Offer one input transaction, with an optional idle gap first.
  task automatic send_item(logic kind, int x, int y, int z, logic signed [15:0] v);
    if ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.x <= COORD_W'(x);
    in_ch.y <= COORD_W'(y);
    in_ch.z <= COORD_W'(z);
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(kind, x, y, z, v);
  endtask

  // Write all eight registers on consecutive cycles.
  task automatic write_regs(logic [CFG_DATA_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Let every outstanding query finish before touching the registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_derivs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_inv();
    case ($urandom_range(4))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'd256;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] vals [8];
    int nx, ny, nz;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WRITE;
    in_ch.x = '0;
    in_ch.y = '0;
    in_ch.z = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    hold_req = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    send_gap_pct = 20;
    recv_stall_pct = 48;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Idling pattern: sender light and receiver heavy, then swapped, then none.
      send_gap_pct   = p < 3 ? 20 : (p < 6 ? 48 : 0);
      recv_stall_pct = p < 3 ? 48 : (p < 6 ? 20 : 0);

      // Register settings: one long axis per early phase, out-of-range sizes,
      // a zero inverse spacing, then small random volumes.
      case (p)
        0: vals = '{16'd32, 16'd1, 16'd1, CFG_DATA_W'(BORDER_FIXED), 16'h8000, 16'hFFFF,
                    16'd1, 16'd256};
        1: vals = '{16'd1, 16'd32, 16'd1, CFG_DATA_W'(BORDER_REPL), 16'h7FFF, 16'd1,
                    16'hFFFF, 16'd128};
        2: vals = '{16'd1, 16'd1, 16'd32, CFG_DATA_W'(BORDER_FIXED), 16'h7FFF, 16'd256,
                    16'd512, 16'hFFFF};
        3: vals = '{16'd0, 16'd63, 16'd0, CFG_DATA_W'(BORDER_REPL), 16'h1234, 16'd384,
                    16'd200, 16'd1};
        4: vals = '{16'd3, 16'd3, 16'd3, CFG_DATA_W'(BORDER_FIXED), 16'h8000, 16'd0,
                    16'hFFFF, 16'hFFFF};
        default: vals = '{CFG_DATA_W'($urandom_range(1, 5)), CFG_DATA_W'($urandom_range(1, 5)),
                          CFG_DATA_W'($urandom_range(1, 5)), CFG_DATA_W'($urandom_range(1)),
                          CFG_DATA_W'($urandom), pick_inv(), pick_inv(), pick_inv()};
      endcase
      write_regs(vals);
      nx = board.span(0);
      ny = board.span(1);
      nz = board.span(2);

      // Load the whole volume in use so no query reads an unwritten voxel.
      for (int z = 0; z < nz; z++)
        for (int y = 0; y < ny; y++)
          for (int x = 0; x < nx; x++)
            send_item(KIND_WRITE, x, y, z, pick_sample());

      // Directed corners, saturating coordinates and ignored outside writes.
      if (p == 0) begin
        send_item(KIND_QUERY, 0, 0, 0, 16'sh0);
        send_item(KIND_QUERY, 31, 31, 31, 16'shFFFF);
        send_item(KIND_QUERY, 1, 0, 0, 16'sh0);
        send_item(KIND_QUERY, 30, 0, 0, 16'sh0);
        send_item(KIND_WRITE, 31, 31, 31, 16'sh7FFF);
        send_item(KIND_WRITE, 0, 1, 0, 16'sh8000);
        send_item(KIND_QUERY, 31, 5, 17, 16'sh0);
        send_item(KIND_QUERY, 15, 0, 0, 16'sh0);
      end

      if (p == 6) hold_req <= 1'b1;

      // Random mix of queries and overwrites, some writes landing outside.
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if ($urandom_range(99) < 65)
          send_item(KIND_QUERY, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                    16'($urandom));
        else if ($urandom_range(3) == 0)
          send_item(KIND_WRITE, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                    16'($urandom));
        else
          send_item(KIND_WRITE, $urandom_range(nx - 1), $urandom_range(ny - 1),
                    $urandom_range(nz - 1), pick_sample());
      end
      drain();
    end

    if (board.pending_derivs.size() != 0) begin
      $error("%0d predicted results never arrived", board.pending_derivs.size());
      board.fail_count++;
    end
    if (board.fail_count == 0) begin
      $display("[voxel_derivative_stencil_core] OK");
    end else begin
      $display("[voxel_derivative_stencil_core] ERROR");
    end
    $finish;
  end

endmodule
